FILE: rtl/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

	// Fixed widths of the beat fields
	parameter int STATUS_W = 2;
	parameter int INDEX_W  = 4;
	parameter int FIELD_W  = 16;

	// Item kinds
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED     = 2'd0,
		ST_NOT_ALLOCATED = 2'd1,
		ST_LOADED        = 2'd2,
		ST_FULL          = 2'd3
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// Control half of the search token that walks the cell row
	typedef struct packed {
		logic valid;
		logic found;
	} tok_ctl_t;

endpackage

FILE: rtl/ffba_if.sv
`timescale 1ns / 1ps

// Request channel: one beat is a load or an allocation request
interface ffba_req_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [ffba_pkg::FIELD_W-1:0] size_value;

	modport source (output valid, output op, output size_value, input ready);
	modport sink   (input valid, input op, input size_value, output ready);
endinterface

// Result channel: one beat per accepted request beat
interface ffba_res_if;
	logic                          valid;
	logic                          ready;
	logic [ffba_pkg::STATUS_W-1:0] status;
	logic [ffba_pkg::INDEX_W-1:0]  part_index;
	logic [ffba_pkg::FIELD_W-1:0]  part_size;
	logic [ffba_pkg::FIELD_W-1:0]  leftover;

	modport source (output valid, output status, output part_index, output part_size,
		output leftover, input ready);
	modport sink   (input valid, input status, input part_index, input part_size,
		input leftover, output ready);
endinterface

FILE: rtl/ffba_cell.sv
`timescale 1ns / 1ps

// One partition slot. Holds size and free flag, and passes the search
// token to the next slot every cycle. The first free slot that fits
// claims the token and stamps its index, size and leftover into it.
module ffba_cell #(
	parameter int SIZE_BITS = 16,
	parameter int IDX_W     = 4,
	parameter int CELL_IDX  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// load write, broadcast to all cells
	input  logic                 load_we,
	input  logic [IDX_W-1:0]     load_idx,
	input  logic [SIZE_BITS-1:0] load_size,
	// token from the previous cell
	input  ffba_pkg::tok_ctl_t   in_ctl,
	input  logic [SIZE_BITS-1:0] in_req,
	input  logic [IDX_W-1:0]     in_idx,
	input  logic [SIZE_BITS-1:0] in_size,
	input  logic [SIZE_BITS-1:0] in_left,
	// token to the next cell
	output ffba_pkg::tok_ctl_t   out_ctl,
	output logic [SIZE_BITS-1:0] out_req,
	output logic [IDX_W-1:0]     out_idx,
	output logic [SIZE_BITS-1:0] out_size,
	output logic [SIZE_BITS-1:0] out_left
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [SIZE_BITS-1:0] size_q;
	logic                 free_q;
	ffba_pkg::tok_ctl_t   ctl_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] psize_q;
	logic [SIZE_BITS-1:0] left_q;

	logic load_hit;
	logic hit;

	assign load_hit = load_we && (load_idx == MY_IDX);
	assign hit      = in_ctl.valid && !in_ctl.found && free_q && (size_q >= in_req);

	// slot contents; size needs no reset, only loaded slots are ever free
	always_ff @(posedge clk) begin
		if (load_hit) begin
			size_q <= load_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= 1'b0;
		end else if (load_hit) begin
			free_q <= 1'b1;
		end else if (hit) begin
			free_q <= 1'b0;
		end
	end

	// token control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid <= in_ctl.valid;
			ctl_q.found <= in_ctl.found || hit;
		end
	end

	// token payload, stamped on a claim
	always_ff @(posedge clk) begin
		req_q <= in_req;
		if (hit) begin
			idx_q   <= MY_IDX;
			psize_q <= size_q;
			left_q  <= size_q - in_req;
		end else begin
			idx_q   <= in_idx;
			psize_q <= in_size;
			left_q  <= in_left;
		end
	end

	assign out_ctl  = ctl_q;
	assign out_req  = req_q;
	assign out_idx  = idx_q;
	assign out_size = psize_q;
	assign out_left = left_q;

endmodule

FILE: rtl/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps

// First-fit fixed-partition allocator. A load beat appends one partition
// size to the table (status loaded, or table full once PARTITIONS are
// loaded); its result is valid in the cycle after acceptance. A request beat
// sends a search token down a row of PARTITIONS slot cells, one cell per
// cycle; the lowest free slot whose size fits claims it, and the result
// leaves the end of the row into the result register. One item is in
// work at a time; the next beat is taken only once the result register
// is empty or its waiting result is being taken. Partitions are never
// released; only reset empties the table.
module first_fit_block_allocator_top #(
	parameter int PARTITIONS = 16,
	parameter int SIZE_BITS  = 16
) (
	input logic      clk,
	input logic      arst_n,
	ffba_req_if.sink   req,
	ffba_res_if.source res
);

	localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam int CNT_W = $clog2(PARTITIONS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PARTITIONS);

	ffba_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;

	logic                          res_valid_q;
	logic [ffba_pkg::STATUS_W-1:0] res_status_q;
	logic [ffba_pkg::INDEX_W-1:0]  res_index_q;
	logic [ffba_pkg::FIELD_W-1:0]  res_size_q;
	logic [ffba_pkg::FIELD_W-1:0]  res_left_q;

	logic                 accept;
	logic                 is_load;
	logic                 is_alloc;
	logic                 full;
	logic                 load_we;
	logic [SIZE_BITS-1:0] req_size;

	// token chain, position 0 is the entry, position PARTITIONS the exit
	ffba_pkg::tok_ctl_t   ch_ctl  [0:PARTITIONS];
	logic [SIZE_BITS-1:0] ch_req  [0:PARTITIONS];
	logic [IDX_W-1:0]     ch_idx  [0:PARTITIONS];
	logic [SIZE_BITS-1:0] ch_size [0:PARTITIONS];
	logic [SIZE_BITS-1:0] ch_left [0:PARTITIONS];

	// handshake and decode
	assign req.ready = (state_q == ffba_pkg::S_IDLE) && (!res_valid_q || res.ready);
	assign accept    = req.valid && req.ready;
	assign is_load   = accept && (req.op == ffba_pkg::OP_LOAD);
	assign is_alloc  = accept && (req.op == ffba_pkg::OP_ALLOC);
	assign full      = (count_q == CNT_FULL);
	assign load_we   = is_load && !full;
	assign req_size  = SIZE_BITS'(req.size_value);

	// token entry
	assign ch_ctl[0].valid = is_alloc;
	assign ch_ctl[0].found = 1'b0;
	assign ch_req[0]       = req_size;
	assign ch_idx[0]       = '0;
	assign ch_size[0]      = '0;
	assign ch_left[0]      = '0;

	// row of slot cells
	for (genvar i = 0; i < PARTITIONS; i++) begin : g_cell
		ffba_cell #(
			.SIZE_BITS(SIZE_BITS),
			.IDX_W    (IDX_W),
			.CELL_IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load_we  (load_we),
			.load_idx (count_q[IDX_W-1:0]),
			.load_size(req_size),
			.in_ctl   (ch_ctl[i]),
			.in_req   (ch_req[i]),
			.in_idx   (ch_idx[i]),
			.in_size  (ch_size[i]),
			.in_left  (ch_left[i]),
			.out_ctl  (ch_ctl[i+1]),
			.out_req  (ch_req[i+1]),
			.out_idx  (ch_idx[i+1]),
			.out_size (ch_size[i+1]),
			.out_left (ch_left[i+1])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffba_pkg::S_IDLE: begin
				if (is_alloc) begin
					state_d = ffba_pkg::S_SCAN;
				end
			end
			ffba_pkg::S_SCAN: begin
				if (ch_ctl[PARTITIONS].valid) begin
					state_d = ffba_pkg::S_IDLE;
				end
			end
			default: state_d = ffba_pkg::S_IDLE;
		endcase
	end

	// loaded partition count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load_we) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (is_load || ch_ctl[PARTITIONS].valid) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (is_load) begin
			if (full) begin
				res_status_q <= ffba_pkg::ST_FULL;
				res_index_q  <= '0;
				res_size_q   <= '0;
			end else begin
				res_status_q <= ffba_pkg::ST_LOADED;
				res_index_q  <= ffba_pkg::INDEX_W'(count_q[IDX_W-1:0]);
				res_size_q   <= ffba_pkg::FIELD_W'(req_size);
			end
			res_left_q <= '0;
		end else if (ch_ctl[PARTITIONS].valid) begin
			if (ch_ctl[PARTITIONS].found) begin
				res_status_q <= ffba_pkg::ST_ALLOCATED;
				res_index_q  <= ffba_pkg::INDEX_W'(ch_idx[PARTITIONS]);
				res_size_q   <= ffba_pkg::FIELD_W'(ch_size[PARTITIONS]);
				res_left_q   <= ffba_pkg::FIELD_W'(ch_left[PARTITIONS]);
			end else begin
				res_status_q <= ffba_pkg::ST_NOT_ALLOCATED;
				res_index_q  <= '0;
				res_size_q   <= '0;
				res_left_q   <= '0;
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = res_status_q;
	assign res.part_index = res_index_q;
	assign res.part_size  = res_size_q;
	assign res.leftover   = res_left_q;

endmodule

FILE: tb/sv/first_fit_block_allocator_top_test.sv
`timescale 1ns / 1ps

module first_fit_block_allocator_top_test;

	localparam int SLOTS        = 16;
	localparam int RANDOM_ITEMS = 1180;
	localparam int CYCLE_LIMIT  = 400000;

	// One expected result beat
	typedef struct {
		ffba_pkg::status_t            status;
		logic [ffba_pkg::INDEX_W-1:0] part_index;
		logic [ffba_pkg::FIELD_W-1:0] part_size;
		logic [ffba_pkg::FIELD_W-1:0] leftover;
	} alloc_result_t;

	// Mirror of the partition table plus the results still owed by the block
	class partition_ledger;
		logic [ffba_pkg::FIELD_W-1:0] sizes[SLOTS];
		bit                           in_free[SLOTS];
		int                           loaded;
		alloc_result_t                outstanding[$];
		int                           mismatches;

		function new();
			loaded = 0;
			mismatches = 0;
			foreach (in_free[i]) begin
				in_free[i] = 1'b0;
				sizes[i] = '0;
			end
		endfunction

		// Apply one accepted request beat to the table and queue its result
		function void note_beat(ffba_pkg::op_t op, logic [ffba_pkg::FIELD_W-1:0] sz);
			alloc_result_t r;
			bit            hit;
			r.status = ffba_pkg::ST_NOT_ALLOCATED;
			r.part_index = '0;
			r.part_size = '0;
			r.leftover = '0;
			hit = 1'b0;
			if (op == ffba_pkg::OP_LOAD) begin
				if (loaded >= SLOTS) begin
					r.status = ffba_pkg::ST_FULL;
				end else begin
					sizes[loaded] = sz;
					in_free[loaded] = 1'b1;
					r.status = ffba_pkg::ST_LOADED;
					r.part_index = ffba_pkg::INDEX_W'(loaded);
					r.part_size = sz;
					loaded++;
				end
			end else begin
				// first fit: lowest free slot that is big enough
				for (int i = 0; i < loaded; i++) begin
					if (!hit && in_free[i] && sizes[i] >= sz) begin
						hit = 1'b1;
						in_free[i] = 1'b0;
						r.status = ffba_pkg::ST_ALLOCATED;
						r.part_index = ffba_pkg::INDEX_W'(i);
						r.part_size = sizes[i];
						r.leftover = sizes[i] - sz;
					end
				end
			end
			outstanding.push_back(r);
		endfunction

		// Compare one accepted result beat with the oldest expectation
		function void check_beat(logic [ffba_pkg::STATUS_W-1:0] st,
			logic [ffba_pkg::INDEX_W-1:0] idx,
			logic [ffba_pkg::FIELD_W-1:0] psize, logic [ffba_pkg::FIELD_W-1:0] left);
			alloc_result_t e;
			if (outstanding.size() == 0) begin
				$error("result beat with no request waiting: status %0d index %0d",
					st, idx);
				mismatches++;
				return;
			end
			e = outstanding.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				mismatches++;
			end
			if (idx !== e.part_index) begin
				$error("part_index: expected %0d, got %0d", e.part_index, idx);
				mismatches++;
			end
			if (psize !== e.part_size) begin
				$error("part_size: expected %0d, got %0d", e.part_size, psize);
				mismatches++;
			end
			if (left !== e.leftover) begin
				$error("leftover: expected %0d, got %0d", e.leftover, left);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int   cycles = 0;

	partition_ledger ledger;

	ffba_req_if req_ch();
	ffba_res_if res_ch();

	first_fit_block_allocator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side back-pressure, off during the steady stretch
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	// Track accepted beats on both channels
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			ledger.note_beat(ffba_pkg::op_t'(req_ch.op), req_ch.size_value);
		if (arst_n && res_ch.valid && res_ch.ready)
			ledger.check_beat(res_ch.status, res_ch.part_index, res_ch.part_size,
				res_ch.leftover);
	end

	// Present one beat, with random idle cycles ahead of it; returns at the
	// falling edge after acceptance with valid still high
	task automatic send_beat(ffba_pkg::op_t op, logic [ffba_pkg::FIELD_W-1:0] sz);
		while (!steady && $urandom_range(99) < 27) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.size_value <= sz;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Hold the request side until every owed result has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (ledger.outstanding.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [ffba_pkg::FIELD_W-1:0] sz;
		int                           pick;
		int                           slot;

		ledger = new();
		steady = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = ffba_pkg::OP_LOAD;
		req_ch.size_value = '0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty table, size extremes, zero-size and exact fits, misses
		send_beat(ffba_pkg::OP_ALLOC, 16'd0);
		send_beat(ffba_pkg::OP_LOAD, 16'h0000);
		send_beat(ffba_pkg::OP_LOAD, 16'hFFFF);
		send_beat(ffba_pkg::OP_LOAD, 16'd100);
		send_beat(ffba_pkg::OP_LOAD, 16'h5555);
		send_beat(ffba_pkg::OP_LOAD, 16'hAAAA);
		send_beat(ffba_pkg::OP_ALLOC, 16'd0);
		send_beat(ffba_pkg::OP_ALLOC, 16'hFFFF);
		send_beat(ffba_pkg::OP_ALLOC, 16'hFFFF);
		send_beat(ffba_pkg::OP_ALLOC, 16'd50);
		send_beat(ffba_pkg::OP_ALLOC, 16'hAAAB);
		send_beat(ffba_pkg::OP_ALLOC, 16'd101);
		send_beat(ffba_pkg::OP_ALLOC, 16'hAAAA);
		send_beat(ffba_pkg::OP_ALLOC, 16'd1);
		wait_drained();

		// Random: sparse loads fill the table while requests of mixed sizes
		// chase it; near-fit sizes hit the compare boundary
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 700 && n < 850);
			if (n == 600)
				wait_drained();
			if ($urandom_range(99) < 3) begin
				sz = $urandom_range(1) ? ffba_pkg::FIELD_W'($urandom)
					: ffba_pkg::FIELD_W'($urandom_range(1023));
				send_beat(ffba_pkg::OP_LOAD, sz);
			end else begin
				pick = $urandom_range(9);
				if (pick < 4) begin
					sz = ffba_pkg::FIELD_W'($urandom_range(255));
				end else if (pick < 7 || ledger.loaded == 0) begin
					sz = ffba_pkg::FIELD_W'($urandom);
				end else begin
					slot = $urandom_range(ledger.loaded - 1);
					sz = ledger.sizes[slot] + ffba_pkg::FIELD_W'($urandom_range(2)) - 16'd1;
				end
				send_beat(ffba_pkg::OP_ALLOC, sz);
			end
		end
		steady = 1'b0;
		req_ch.valid <= 1'b0;

		// Drain, then wait out at least a full scan for stray results
		while (ledger.outstanding.size() != 0)
			@(negedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		if (ledger.mismatches == 0 && ledger.outstanding.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
